// ===== hw/rtl/a2b_pkg.sv =====
// shared types and constants for the length-prefix to start-code converter
// no dependencies
`timescale 1ns / 1ps

package a2b_pkg;

   localparam int PS_BYTES_DEF = 56;
   localparam int Q_DEPTH      = 4;
   localparam int Q_PTR_W      = $clog2(Q_DEPTH);

   localparam int unsigned HDR_BYTES = 5;
   localparam logic [4:0]  NAL_TYPE_MASK = 5'h1f;
   localparam logic [4:0]  NAL_IDR       = 5'd5;

   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_PKT_ERR = 2'd1;
   localparam logic [1:0] KIND_EXT_ERR = 2'd2;

   // one command per input transfer that causes results, emitted in field order
   typedef struct packed {
      logic       ps;
      logic       sc;
      logic       sc_four;
      logic       dat;
      logic [7:0] data;
      logic       err;
      logic [1:0] kind;
   } cmd_type;

endpackage

// ===== hw/rtl/a2b_front.sv =====
// front end: parses extradata and packet bytes, writes the parameter-set store
// and issues result commands; uses a2b_pkg
`timescale 1ns / 1ps

module a2b_front
   import a2b_pkg::*;
#(
   parameter int PS_BYTES = PS_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,
   input  logic [1:0]                      req_tuser,
   input  logic                            req_tlast,
   input  logic                            q_full,
   input  logic                            q_empty,
   input  logic                            back_idle,
   output logic                            push,
   output cmd_type                         cmd,
   output logic                            wr_en,
   output logic [$clog2(PS_BYTES)-1:0]     wr_addr,
   output logic [7:0]                      wr_data,
   output logic [$clog2(PS_BYTES+1)-1:0]   ps_len
);

   localparam int AW = $clog2(PS_BYTES);
   localparam int LW = $clog2(PS_BYTES + 1);

   typedef enum logic [7:0] {
      PH_HEADER    = 8'b00000001,
      PH_SPS_COUNT = 8'b00000010,
      PH_SIZE_HI   = 8'b00000100,
      PH_SIZE_LO   = 8'b00001000,
      PH_BODY      = 8'b00010000,
      PH_PPS_COUNT = 8'b00100000,
      PH_DONE      = 8'b01000000,
      PH_DEAD      = 8'b10000000
   } phase_type;

   phase_type     ph_ff, ph_in;
   logic [15:0]   cnt_ff, cnt_in;
   logic [7:0]    ul_ff, ul_in;
   logic          pps_ff, pps_in;
   logic [LW-1:0] psl_ff, psl_in;
   logic [1:0]    pre_ff, pre_in;
   logic [23:0]   pl_ff, pl_in;
   logic [31:0]   acc_ff, acc_in;
   logic [2:0]    lbs_ff, lbs_in;
   logic [23:0]   nl_ff, nl_in;
   logic          fnf_ff, fnf_in;
   logic          drp_ff, drp_in;

   logic [7:0]  b;
   logic        take;
   logic [16:0] fit_sum;

   function automatic phase_type after_unit(input logic [7:0] left, input logic in_pps);
      phase_type p;
      if (left != 8'd0) begin
         p = PH_SIZE_HI;
      end else if (in_pps) begin
         p = PH_DONE;
      end else begin
         p = PH_PPS_COUNT;
      end
      return p;
   endfunction

   assign b          = req_tdata[7:0];
   assign req_tready = (pre_ff == 2'd0) && !q_full && (req_tuser[0] || (q_empty && back_idle));
   assign take       = req_tvalid && req_tready;
   assign ps_len     = psl_ff;
   assign push       = cmd.ps || cmd.sc || cmd.dat || cmd.err;

   always_comb begin
      ph_in   = ph_ff;
      cnt_in  = cnt_ff;
      ul_in   = ul_ff;
      pps_in  = pps_ff;
      psl_in  = psl_ff;
      pre_in  = pre_ff;
      pl_in   = pl_ff;
      acc_in  = acc_ff;
      lbs_in  = lbs_ff;
      nl_in   = nl_ff;
      fnf_in  = fnf_ff;
      drp_in  = drp_ff;
      cmd     = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = 8'h00;
      fit_sum = '0;
      if (pre_ff != 2'd0) begin
         // rest of the start code in front of a stored unit
         wr_en   = 1'b1;
         wr_addr = psl_ff[AW-1:0];
         wr_data = (pre_ff == 2'd1) ? 8'h01 : 8'h00;
         psl_in  = psl_ff + 1'b1;
         pre_in  = pre_ff - 1'b1;
      end else if (take && !req_tuser[0]) begin
         if (req_tuser[1]) begin
            psl_in = '0;
            ph_in  = PH_HEADER;
            cnt_in = '0;
            ul_in  = '0;
            pps_in = 1'b0;
         end
         unique case (ph_in)
            PH_HEADER: begin
               cnt_in = cnt_in + 16'd1;
               if (cnt_in >= 16'(HDR_BYTES)) begin
                  cnt_in = '0;
                  ph_in  = PH_SPS_COUNT;
               end
            end
            PH_SPS_COUNT: begin
               ul_in  = {3'b000, b[4:0] & NAL_TYPE_MASK};
               pps_in = 1'b0;
               ph_in  = (ul_in != 8'd0) ? PH_SIZE_HI : PH_PPS_COUNT;
            end
            PH_SIZE_HI: begin
               cnt_in = {b, 8'h00};
               ph_in  = PH_SIZE_LO;
            end
            PH_SIZE_LO: begin
               cnt_in  = cnt_in | {8'h00, b};
               fit_sum = 17'(psl_in) + 17'd4 + {1'b0, cnt_in};
               if (fit_sum > 17'(PS_BYTES)) begin
                  psl_in   = '0;
                  ph_in    = PH_DEAD;
                  cmd.err  = 1'b1;
                  cmd.kind = KIND_EXT_ERR;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = psl_in[AW-1:0];
                  psl_in  = psl_in + 1'b1;
                  pre_in  = 2'd3;
                  if (cnt_in == 16'd0) begin
                     ul_in = ul_in - 8'd1;
                     ph_in = after_unit(ul_in, pps_in);
                  end else begin
                     ph_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               if (psl_in < LW'(PS_BYTES)) begin
                  wr_en   = 1'b1;
                  wr_addr = psl_in[AW-1:0];
                  wr_data = b;
                  psl_in  = psl_in + 1'b1;
               end
               cnt_in = cnt_in - 16'd1;
               if (cnt_in == 16'd0) begin
                  ul_in = ul_in - 8'd1;
                  ph_in = after_unit(ul_in, pps_in);
               end
            end
            PH_PPS_COUNT: begin
               ul_in  = b;
               pps_in = 1'b1;
               ph_in  = (ul_in != 8'd0) ? PH_SIZE_HI : PH_DONE;
            end
            default: begin
            end
         endcase
         if (req_tlast && ph_in != PH_DONE && ph_in != PH_DEAD) begin
            psl_in   = '0;
            ph_in    = PH_DEAD;
            pre_in   = 2'd0;
            cmd.err  = 1'b1;
            cmd.kind = KIND_EXT_ERR;
         end
      end else if (take) begin
         if (req_tuser[1]) begin
            pl_in  = req_tdata[31:8];
            acc_in = '0;
            lbs_in = '0;
            nl_in  = '0;
            fnf_in = 1'b1;
            drp_in = 1'b0;
         end
         if (drp_in) begin
            if (pl_in != 24'd0) begin
               pl_in = pl_in - 24'd1;
            end
         end else if (pl_in == 24'd0) begin
            drp_in   = 1'b1;
            cmd.err  = 1'b1;
            cmd.kind = KIND_PKT_ERR;
         end else begin
            if (lbs_in == 3'd4) begin
               cmd.ps      = ((b[4:0] & NAL_TYPE_MASK) == NAL_IDR);
               cmd.sc      = 1'b1;
               cmd.sc_four = fnf_in;
               fnf_in      = 1'b0;
               lbs_in      = '0;
               acc_in      = '0;
               cmd.dat     = 1'b1;
               cmd.data    = b;
               nl_in       = nl_in - 24'd1;
            end else if (nl_in != 24'd0) begin
               cmd.dat  = 1'b1;
               cmd.data = b;
               nl_in    = nl_in - 24'd1;
            end else if (lbs_in == 3'd0 && pl_in < 24'd4) begin
               drp_in   = 1'b1;
               cmd.err  = 1'b1;
               cmd.kind = KIND_PKT_ERR;
            end else begin
               acc_in = {acc_in[23:0], b};
               lbs_in = lbs_in + 3'd1;
               if (lbs_in == 3'd4) begin
                  if (acc_in > {8'h00, pl_in - 24'd1}) begin
                     drp_in   = 1'b1;
                     cmd.err  = 1'b1;
                     cmd.kind = KIND_PKT_ERR;
                  end else begin
                     nl_in = acc_in[23:0];
                     if (nl_in == 24'd0) begin
                        cmd.sc      = 1'b1;
                        cmd.sc_four = fnf_in;
                        fnf_in      = 1'b0;
                        lbs_in      = '0;
                        acc_in      = '0;
                     end
                  end
               end
            end
            pl_in = pl_in - 24'd1;
            if (req_tlast && !drp_in &&
                (pl_in != 24'd0 || nl_in != 24'd0 || lbs_in != 3'd0)) begin
               drp_in   = 1'b1;
               cmd.err  = 1'b1;
               cmd.kind = KIND_PKT_ERR;
               pl_in    = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff  <= PH_HEADER;
         cnt_ff <= '0;
         ul_ff  <= '0;
         pps_ff <= 1'b0;
         psl_ff <= '0;
         pre_ff <= '0;
         pl_ff  <= '0;
         acc_ff <= '0;
         lbs_ff <= '0;
         nl_ff  <= '0;
         fnf_ff <= 1'b1;
         drp_ff <= 1'b0;
      end else begin
         ph_ff  <= ph_in;
         cnt_ff <= cnt_in;
         ul_ff  <= ul_in;
         pps_ff <= pps_in;
         psl_ff <= psl_in;
         pre_ff <= pre_in;
         pl_ff  <= pl_in;
         acc_ff <= acc_in;
         lbs_ff <= lbs_in;
         nl_ff  <= nl_in;
         fnf_ff <= fnf_in;
         drp_ff <= drp_in;
      end
   end

endmodule

// ===== hw/rtl/a2b_queue.sv =====
// short command queue between the parser and the byte sequencer
// uses a2b_pkg
`timescale 1ns / 1ps

module a2b_queue
   import a2b_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   cmd_type              ent_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [Q_PTR_W:0]     cnt_ff, cnt_in;

   assign head  = ent_ff[rp_ff];
   assign full  = (cnt_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign empty = (cnt_ff == '0);

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/a2b_back.sv =====
// back end: expands commands into output bytes, holds the parameter-set store
// and the result register; uses a2b_pkg
`timescale 1ns / 1ps

module a2b_back
   import a2b_pkg::*;
#(
   parameter int PS_BYTES = PS_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cmd_type                         head,
   input  logic                            q_empty,
   output logic                            pop,
   input  logic                            wr_en,
   input  logic [$clog2(PS_BYTES)-1:0]     wr_addr,
   input  logic [7:0]                      wr_data,
   input  logic [$clog2(PS_BYTES+1)-1:0]   ps_len,
   output logic                            idle,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int AW = $clog2(PS_BYTES);
   localparam int LW = $clog2(PS_BYTES + 1);

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_PS   = 5'b00010,
      B_SC   = 5'b00100,
      B_DAT  = 5'b01000,
      B_ERR  = 5'b10000
   } bphase_type;

   logic [7:0]    mem [PS_BYTES];
   logic [7:0]    rd_ff;
   bphase_type    ph_ff, ph_in, after;
   logic [LW-1:0] idx_ff, idx_in;
   cmd_type       cur_ff, cur_in;
   logic          ov_ff, ov_in;
   logic [7:0]    ob_ff, ob_in;
   logic [1:0]    ok_ff, ok_in;
   logic          ol_ff, ol_in;
   logic          emit, seg_end;
   logic [7:0]    byte_val;
   logic [1:0]    kind_val;

   function automatic bphase_type next_seg(input bphase_type from, input cmd_type c,
                                           input logic ps_nz);
      bphase_type p;
      logic t_ps, t_sc, t_dat, t_err;
      t_ps  = (from == B_IDLE) && c.ps && ps_nz;
      t_sc  = (from == B_IDLE || from == B_PS) && c.sc;
      t_dat = (from == B_IDLE || from == B_PS || from == B_SC) && c.dat;
      t_err = (from != B_ERR) && c.err;
      if (t_ps) begin
         p = B_PS;
      end else if (t_sc) begin
         p = B_SC;
      end else if (t_dat) begin
         p = B_DAT;
      end else if (t_err) begin
         p = B_ERR;
      end else begin
         p = B_IDLE;
      end
      return p;
   endfunction

   assign idle       = (ph_ff == B_IDLE);
   assign emit       = (ph_ff != B_IDLE) && (!ov_ff || rsp_tready);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = ob_ff;
   assign rsp_tuser  = ok_ff;
   assign rsp_tlast  = ol_ff;

   always_comb begin
      seg_end  = 1'b1;
      byte_val = 8'h00;
      kind_val = KIND_DATA;
      unique case (ph_ff)
         B_PS: begin
            seg_end  = (idx_ff == ps_len - 1'b1);
            byte_val = rd_ff;
         end
         B_SC: begin
            seg_end  = (idx_ff == (cur_ff.sc_four ? LW'(3) : LW'(2)));
            byte_val = seg_end ? 8'h01 : 8'h00;
         end
         B_DAT: begin
            byte_val = cur_ff.data;
         end
         B_ERR: begin
            kind_val = cur_ff.kind;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      after  = next_seg(ph_ff, cur_ff, ps_len != '0);
      ph_in  = ph_ff;
      idx_in = idx_ff;
      cur_in = cur_ff;
      pop    = 1'b0;
      if (emit) begin
         if (seg_end) begin
            idx_in = '0;
            if (after != B_IDLE) begin
               ph_in = after;
            end else if (!q_empty) begin
               pop    = 1'b1;
               cur_in = head;
               ph_in  = next_seg(B_IDLE, head, ps_len != '0);
            end else begin
               ph_in = B_IDLE;
            end
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end else if (ph_ff == B_IDLE && !q_empty) begin
         pop    = 1'b1;
         cur_in = head;
         idx_in = '0;
         ph_in  = next_seg(B_IDLE, head, ps_len != '0);
      end
      ov_in = ov_ff;
      ob_in = ob_ff;
      ok_in = ok_ff;
      ol_in = ol_ff;
      if (emit) begin
         ov_in = 1'b1;
         ob_in = byte_val;
         ok_in = kind_val;
         ol_in = seg_end && (after == B_IDLE);
      end else if (rsp_tready) begin
         ov_in = 1'b0;
      end
   end

   // read address follows the next index so rd_ff always holds the current entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[idx_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      ob_ff  <= ob_in;
      ok_ff  <= ok_in;
      ol_ff  <= ol_in;
      if (reset) begin
         ph_ff  <= B_IDLE;
         idx_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         ph_ff  <= ph_in;
         idx_ff <= idx_in;
         ov_ff  <= ov_in;
      end
   end

endmodule

// ===== hw/rtl/avcc_to_annexb_converter.sv =====
// length-prefixed H.264 to start-code converter, one byte per transfer
// commands pass the queue and sequencer to the output register; one byte per ready cycle
// packet bytes: one per cycle while the queue has room; IDR units replay the parameter sets
// extradata waits for an empty queue and idle sequencer; storing a start code stalls input
// reset is synchronous; the parameter-set store is not cleared, only its length
`timescale 1ns / 1ps

module avcc_to_annexb_converter
   import a2b_pkg::*;
#(
   parameter int PS_BYTES = PS_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // data_byte, packet_bytes
   input  logic [1:0]  req_tuser,  // req_type, first_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // out_byte
   output logic [1:0]  rsp_tuser,  // result_kind
   output logic        rsp_tlast
);

   localparam int AW = $clog2(PS_BYTES);
   localparam int LW = $clog2(PS_BYTES + 1);

   logic          q_full, q_empty, back_idle, push, pop, wr_en;
   cmd_type       cmd, head;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [LW-1:0] ps_len;

   a2b_front #(.PS_BYTES(PS_BYTES)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser, .req_tlast,
      .q_full, .q_empty, .back_idle, .push, .cmd, .wr_en, .wr_addr, .wr_data, .ps_len
   );

   a2b_queue u_queue (
      .clock, .reset, .push, .push_cmd(cmd), .pop, .head, .full(q_full), .empty(q_empty)
   );

   a2b_back #(.PS_BYTES(PS_BYTES)) u_back (
      .clock, .reset, .head, .q_empty, .pop, .wr_en, .wr_addr, .wr_data, .ps_len,
      .idle(back_idle), .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );

   a_ext_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser[0] |-> q_empty && back_idle)
      else $error("extradata transfer while results pending");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_DATA |-> rsp_tlast)
      else $error("error result not final in its run");

   a_kind_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("bad result kind");

   a_store_quiet: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> back_idle && !pop)
      else $error("store written while sequencer active");

endmodule

// ===== bench/avcc_to_annexb_converter_test.sv =====
// self-checking bench for the length-prefix to start-code converter
// drives extradata and packet byte streams, predicts every result and checks it
// depends on a2b_pkg and avcc_to_annexb_converter
`timescale 1ns / 1ps

module avcc_to_annexb_converter_test;
   import a2b_pkg::*;

   localparam int PS_BYTES = PS_BYTES_DEF;
   localparam int STALL_LIMIT = 5000;

   localparam logic [2:0] EX_HEADER    = 3'd0;
   localparam logic [2:0] EX_SPS_COUNT = 3'd1;
   localparam logic [2:0] EX_SIZE_HI   = 3'd2;
   localparam logic [2:0] EX_SIZE_LO   = 3'd3;
   localparam logic [2:0] EX_BODY      = 3'd4;
   localparam logic [2:0] EX_PPS_COUNT = 3'd5;
   localparam logic [2:0] EX_DONE      = 3'd6;
   localparam logic [2:0] EX_DEAD      = 3'd7;

   localparam logic TYPE_EXTRA  = 1'b0;
   localparam logic TYPE_PACKET = 1'b1;

   localparam int IDLE_NONE   = 0;
   localparam int IDLE_SENDER = 1;
   localparam int IDLE_RECV   = 2;
   localparam int IDLE_BOTH   = 3;

   localparam int PKT_GOOD      = 0;
   localparam int PKT_SHORT_LEN = 1;
   localparam int PKT_LONG_LEN  = 2;
   localparam int PKT_BAD_NAL   = 3;
   localparam int PKT_CUT       = 4;

   typedef struct {
      logic        kind;
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic [23:0] total;
   } byte_item_type;

   typedef struct {
      logic [7:0] data;
      logic [1:0] kind;
      logic       last;
   } out_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   byte_item_type pending_bytes[$];
   out_byte_type  expected_bytes[$];
   int          error_count = 0;
   int          idle_mode = IDLE_NONE;
   int          stall_count = 0;
   bit          req_fired = 1'b0;
   int          pushed = 0;

   // predictor state
   logic [7:0]  ps_store[PS_BYTES];
   int          ps_len = 0;
   logic [2:0]  ex_phase = EX_HEADER;
   logic [31:0] ex_count = 0;
   logic [7:0]  ex_units = 0;
   bit          ex_pps = 1'b0;
   logic [31:0] pk_left = 0;
   logic [31:0] len_acc = 0;
   int          len_seen = 0;
   logic [31:0] nal_left = 0;
   bit          first_nal = 1'b1;
   bit          dropping = 1'b0;
   int          step_results;

   avcc_to_annexb_converter #(.PS_BYTES(PS_BYTES)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),  // data_byte, packet_bytes
      .req_tuser  (req_tuser),  // req_type, first_byte
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),  // out_byte
      .rsp_tuser  (rsp_tuser),  // result_kind
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic put_out(input logic [7:0] b, input logic [1:0] k);
      out_byte_type o;
      o.data = b;
      o.kind = k;
      o.last = 1'b0;
      expected_bytes.push_back(o);
      step_results++;
   endtask

   task automatic store_byte(input logic [7:0] b);
      if (ps_len < PS_BYTES) begin
         ps_store[ps_len] = b;
         ps_len++;
      end
   endtask

   task automatic extra_error();
      ps_len = 0;
      ex_phase = EX_DEAD;
      put_out(8'h00, KIND_EXT_ERR);
   endtask

   task automatic unit_finished();
      ex_units = ex_units - 8'd1;
      if (ex_units != 0) ex_phase = EX_SIZE_HI;
      else ex_phase = ex_pps ? EX_DONE : EX_PPS_COUNT;
   endtask

   task automatic put_start_code();
      put_out(8'h00, KIND_DATA);
      put_out(8'h00, KIND_DATA);
      if (first_nal) put_out(8'h00, KIND_DATA);
      put_out(8'h01, KIND_DATA);
      first_nal = 1'b0;
   endtask

   task automatic packet_error();
      dropping = 1'b1;
      put_out(8'h00, KIND_PKT_ERR);
   endtask

   task automatic predict_extra(input byte_item_type it);
      bit failed;
      failed = 1'b0;
      if (it.first) begin
         ps_len = 0;
         ex_phase = EX_HEADER;
         ex_count = 0;
         ex_units = 0;
         ex_pps = 1'b0;
      end
      case (ex_phase)
         EX_HEADER: begin
            ex_count++;
            if (ex_count >= HDR_BYTES) begin
               ex_count = 0;
               ex_phase = EX_SPS_COUNT;
            end
         end
         EX_SPS_COUNT: begin
            ex_units = {3'b000, it.data[4:0] & NAL_TYPE_MASK};
            ex_pps = 1'b0;
            ex_phase = (ex_units != 0) ? EX_SIZE_HI : EX_PPS_COUNT;
         end
         EX_SIZE_HI: begin
            ex_count = {16'h0, it.data, 8'h00};
            ex_phase = EX_SIZE_LO;
         end
         EX_SIZE_LO: begin
            ex_count = ex_count | {24'h0, it.data};
            if (ps_len + 4 + ex_count > PS_BYTES) begin
               extra_error();
               failed = 1'b1;
            end else begin
               store_byte(8'h00);
               store_byte(8'h00);
               store_byte(8'h00);
               store_byte(8'h01);
               if (ex_count == 0) unit_finished();
               else ex_phase = EX_BODY;
            end
         end
         EX_BODY: begin
            store_byte(it.data);
            ex_count = (ex_count - 1) & 32'hffff;
            if (ex_count == 0) unit_finished();
         end
         EX_PPS_COUNT: begin
            ex_units = it.data;
            ex_pps = 1'b1;
            ex_phase = (ex_units != 0) ? EX_SIZE_HI : EX_DONE;
         end
         default: ;
      endcase
      if (!failed && it.last && ex_phase != EX_DONE && ex_phase != EX_DEAD) extra_error();
   endtask

   task automatic predict_packet(input byte_item_type it);
      if (it.first) begin
         pk_left = {8'h00, it.total};
         len_acc = 0;
         len_seen = 0;
         nal_left = 0;
         first_nal = 1'b1;
         dropping = 1'b0;
      end
      if (dropping) begin
         if (pk_left != 0) pk_left--;
      end else if (pk_left == 0) begin
         packet_error();
      end else begin
         if (len_seen == 4) begin
            if ((it.data[4:0] & NAL_TYPE_MASK) == NAL_IDR)
               for (int i = 0; i < ps_len; i++) put_out(ps_store[i], KIND_DATA);
            put_start_code();
            len_seen = 0;
            len_acc = 0;
            put_out(it.data, KIND_DATA);
            nal_left--;
         end else if (nal_left != 0) begin
            put_out(it.data, KIND_DATA);
            nal_left--;
         end else if (len_seen == 0 && pk_left < 4) begin
            packet_error();
         end else begin
            len_acc = {len_acc[23:0], it.data};
            len_seen++;
            if (len_seen == 4) begin
               if (len_acc > pk_left - 1) begin
                  packet_error();
               end else begin
                  nal_left = len_acc;
                  if (nal_left == 0) begin
                     put_start_code();
                     len_seen = 0;
                     len_acc = 0;
                  end
               end
            end
         end
         pk_left--;
         if (it.last && !dropping && (pk_left != 0 || nal_left != 0 || len_seen != 0)) begin
            packet_error();
            pk_left = 0;
         end
      end
   endtask

   task automatic predict_byte(input byte_item_type it);
      step_results = 0;
      if (it.kind == TYPE_EXTRA) predict_extra(it);
      else predict_packet(it);
      if (step_results > 0) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
   endtask

   // stimulus builders
   task automatic push_byte(input logic k, input logic [7:0] b, input logic f, input logic l,
                            input logic [23:0] tot);
      byte_item_type it;
      it.kind = k;
      it.data = b;
      it.first = f;
      it.last = l;
      it.total = tot;
      pending_bytes.push_back(it);
      pushed++;
   endtask

   task automatic add_noise(input int n);
      repeat (n) push_byte(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                           24'($urandom));
   endtask

   task automatic add_unit(ref logic [7:0] b[$], input int maxsz);
      int sz;
      sz = $urandom_range(maxsz);
      b.push_back(8'(sz >> 8));
      b.push_back(8'(sz));
      repeat (sz) b.push_back(8'($urandom));
   endtask

   task automatic add_extra(input int nsps, input int npps, input int maxsz, input bit cut);
      logic [7:0] b[$];
      int n;
      repeat (5) b.push_back(8'($urandom));
      b.push_back({3'($urandom), 5'(nsps)});
      repeat (nsps) add_unit(b, maxsz);
      b.push_back(8'(npps));
      repeat (npps) add_unit(b, maxsz);
      if (cut) begin
         n = $urandom_range(1, b.size() - 6);
         repeat (n) void'(b.pop_back());
      end
      foreach (b[i]) push_byte(TYPE_EXTRA, b[i], i == 0, i == b.size() - 1, 24'($urandom));
   endtask

   task automatic add_packet(input int nnal, input int mode);
      logic [7:0] b[$];
      int len, wlen, n;
      logic [23:0] tot;
      for (int k = 0; k < nnal; k++) begin
         len = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 10);
         wlen = len;
         if (mode == PKT_BAD_NAL && k == nnal - 1) wlen = len + $urandom_range(1, 300);
         b.push_back(8'(wlen >> 24));
         b.push_back(8'(wlen >> 16));
         b.push_back(8'(wlen >> 8));
         b.push_back(8'(wlen));
         if (len > 0) begin
            b.push_back(($urandom_range(2) == 0) ? {3'($urandom), NAL_IDR} : 8'($urandom));
            repeat (len - 1) b.push_back(8'($urandom));
         end
      end
      tot = 24'(b.size());
      case (mode)
         PKT_SHORT_LEN: tot = tot - 24'($urandom_range(1, 3));
         PKT_LONG_LEN:  tot = tot + 24'($urandom_range(1, 5));
         PKT_CUT: begin
            n = $urandom_range(1, b.size() - 1);
            repeat (n) void'(b.pop_back());
         end
         default: ;
      endcase
      foreach (b[i])
         push_byte(TYPE_PACKET, b[i], i == 0, i == b.size() - 1, (i == 0) ? tot : 24'($urandom));
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_tvalid || expected_bytes.size() != 0)
         @(posedge clock);
   endtask

   task automatic add_random(input int target);
      int r, start;
      start = pushed;
      while (pushed - start < target) begin
         r = $urandom_range(99);
         if (r < 55) add_packet($urandom_range(1, 3), PKT_GOOD);
         else if (r < 70) add_packet($urandom_range(1, 3), $urandom_range(PKT_SHORT_LEN, PKT_CUT));
         else if (r < 80) add_extra($urandom_range(0, 2), $urandom_range(0, 2), 8, 1'b0);
         else if (r < 85) add_extra($urandom_range(1, 3), $urandom_range(1, 3), 30, 1'b0);
         else if (r < 90) add_extra($urandom_range(1, 2), $urandom_range(1, 2), 8, 1'b1);
         else add_noise($urandom_range(1, 4));
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_fired) begin
            if (pending_bytes.size() != 0 &&
                !((idle_mode == IDLE_SENDER && $urandom_range(99) < 71) ||
                  (idle_mode == IDLE_BOTH && $urandom_range(99) < 26))) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {pending_bytes[0].total, pending_bytes[0].data};
               req_tuser  <= {pending_bytes[0].first, pending_bytes[0].kind};
               req_tlast  <= pending_bytes[0].last;
               void'(pending_bytes.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < 71) ||
                         (idle_mode == IDLE_BOTH && $urandom_range(99) < 26));
      end
   end

   // monitor
   always @(posedge clock) begin
      byte_item_type it;
      out_byte_type e;
      req_fired = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_fired = 1'b1;
            it.kind  = req_tuser[0];
            it.first = req_tuser[1];
            it.data  = req_tdata[7:0];
            it.total = req_tdata[31:8];
            it.last  = req_tlast;
            predict_byte(it);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected transfer data %02h kind %0d",
                                         rsp_tdata, rsp_tuser));
            end else begin
               e = expected_bytes.pop_front();
               if (rsp_tdata !== e.data || rsp_tuser !== e.kind || rsp_tlast !== e.last)
                  report_mismatch($sformatf("got %02h/%0d/%0b want %02h/%0d/%0b",
                                            rsp_tdata, rsp_tuser, rsp_tlast,
                                            e.data, e.kind, e.last));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_count = 0;
         end else if (pending_bytes.size() != 0 || req_tvalid || expected_bytes.size() != 0) begin
            stall_count++;
            if (stall_count >= STALL_LIMIT) begin
               $display("Testbench completed WITH ERRORS");
               $finish;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed part
      add_extra(2, 1, 8, 1'b0);
      add_packet(2, PKT_GOOD);
      add_noise(2);
      add_packet(1, PKT_SHORT_LEN);
      add_packet(1, PKT_LONG_LEN);
      add_packet(1, PKT_BAD_NAL);
      add_packet(1, PKT_CUT);
      push_byte(TYPE_PACKET, 8'hff, 1'b1, 1'b1, 24'hffffff);
      push_byte(TYPE_PACKET, 8'h00, 1'b1, 1'b0, 24'h000000);
      add_extra(1, 1, 8, 1'b1);
      push_byte(TYPE_EXTRA, 8'h5a, 1'b0, 1'b1, 24'h0);
      add_packet(1, PKT_GOOD);
      wait_drained();

      idle_mode = IDLE_NONE;
      add_random(6);
      wait_drained();
      idle_mode = IDLE_SENDER;
      add_random(6);
      wait_drained();
      idle_mode = IDLE_RECV;
      add_random(6);
      wait_drained();
      idle_mode = IDLE_BOTH;
      add_random(6);
      wait_drained();

      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
